// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define PTGS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true outside reset.
`define PTGS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTGS_ASSERT(lbl, prop, msg)
`define PTGS_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/ptgs_pkg.sv -----
// Types, codes and helpers shared by the point-to-grid splat block.
package ptgs_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_INV_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_INV_PITCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_FACTOR = 3'd5;

    localparam logic [1:0] OP_SPLAT    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_READ_CLR = 2'd2;
    // Spare code: taken and ignored, with no result.
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [31:0] UNIT_Q16 = 32'h0001_0000;
    localparam logic [7:0]  GRAY_MAX = 8'd255;

    // Neighbor groups: each needs a row edge guard and a column edge guard.
    localparam logic [1:0] GRP_UP_LEFT    = 2'd0;
    localparam logic [1:0] GRP_DOWN_RIGHT = 2'd1;
    localparam logic [1:0] GRP_LEFT_DOWN  = 2'd2;
    localparam logic [1:0] GRP_RIGHT_UP   = 2'd3;

    localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, 2'sd0, -2'sd1, 2'sd1,
                                                2'sd0, 2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] NB_DC [8] = '{2'sd0, -2'sd1, -2'sd1, 2'sd0,
                                                2'sd1, 2'sd1, -2'sd1, 2'sd1};
    localparam logic [1:0] NB_GRP [8] = '{GRP_UP_LEFT, GRP_UP_LEFT, GRP_UP_LEFT,
                                          GRP_DOWN_RIGHT, GRP_DOWN_RIGHT,
                                          GRP_DOWN_RIGHT, GRP_LEFT_DOWN,
                                          GRP_RIGHT_UP};

    typedef struct packed {
        logic [31:0] x_min;
        logic [31:0] y_min;
        logic [31:0] z_min;
        logic [31:0] x_inv_pitch;
        logic [31:0] y_inv_pitch;
        logic [31:0] gray_factor;
    } cfg_t;

    typedef struct packed {
        logic [31:0] depth;
        logic [7:0]  gray;
        logic [7:0]  inten;
    } pixel_t;

    // Fill each plane only where it still holds its empty marker.
    function automatic pixel_t fill_pixel(input pixel_t old, input pixel_t nw,
                                          input logic [31:0] zmin);
        pixel_t res;
        res.depth = (old.depth == zmin) ? nw.depth : old.depth;
        res.gray  = (old.gray == 8'd0) ? nw.gray : old.gray;
        res.inten = (old.inten == 8'd0) ? nw.inten : old.inten;
        return res;
    endfunction

endpackage

// ----- rtl/core/ptgs_ifs.sv -----
// Channel interfaces of the point-to-grid splat block.
interface ptgs_pt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         point_red;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
    modport source (output valid, operation, point_x, point_y, point_z, point_red,
                    read_row, read_col, input ready);
    modport sink (input valid, operation, point_x, point_y, point_z, point_red,
                  read_row, read_col, output ready);
endinterface

interface ptgs_px_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] depth_out;
    logic [7:0]         gray_out;
    logic [7:0]         intensity_out;
    modport source (output valid, depth_out, gray_out, intensity_out, input ready);
    modport sink (input valid, depth_out, gray_out, intensity_out, output ready);
endinterface

interface ptgs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ptgs_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ptgs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/ptgs_cfg.sv -----
// Configuration register file of the point-to-grid splat block.
module ptgs_cfg (
    input  logic          clk,
    input  logic          rst_n,
    ptgs_cfg_if.sink      cfg,
    output ptgs_pkg::cfg_t regs
);
    import ptgs_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_X_MIN:       regs_next.x_min = cfg.data;
                REG_Y_MIN:       regs_next.y_min = cfg.data;
                REG_Z_MIN:       regs_next.z_min = cfg.data;
                REG_X_INV_PITCH: regs_next.x_inv_pitch = cfg.data;
                REG_Y_INV_PITCH: regs_next.y_inv_pitch = cfg.data;
                REG_GRAY_FACTOR: regs_next.gray_factor = cfg.data;
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{x_min: 32'd0, y_min: 32'd0, z_min: 32'd0,
                          x_inv_pitch: UNIT_Q16, y_inv_pitch: UNIT_Q16,
                          gray_factor: UNIT_Q16};
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

// ----- rtl/core/point_to_grid_splat_fill.sv -----
// Top level: bins points into depth, gray and intensity planes and reads them back.
//
//  channel   dir  transfer carries
//  points    in   operation, point_x/y/z, point_red, read_row, read_col
//  pixels    out  depth_out, gray_out, intensity_out (one per read)
//  cfg       in   index, data (register write)
//
// One item at a time. A splat takes three steps on the shared 32x32
// multiplier (column, row, gray), one range check, then the centre write and
// eight neighbor read-modify-writes pipelined through the registered-read plane RAM.
// A rejected splat ends at the range check; a read waits while a stalled result is held.
// After reset a clearing pass writes every one of the ROWS*COLS entries to
// zero, one per cycle, and points are not taken until it ends.
// A stalled pixels channel holds its result while the next item is taken.
`include "assert_macros.svh"

module point_to_grid_splat_fill #(
    parameter int ROWS = 256,
    parameter int COLS = 256
) (
    input logic         clk,
    input logic         rst_n,
    ptgs_pt_if.sink     points,
    ptgs_px_if.source   pixels,
    ptgs_cfg_if.sink    cfg
);
    import ptgs_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_SPLAT    = 3'd4;
    localparam logic [2:0] S_DRAIN    = 3'd5;
    localparam logic [2:0] S_RD_ISSUE = 3'd6;
    localparam logic [2:0] S_RD_DATA  = 3'd7;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
        return AW'(r) * AW'(COLS) + AW'(c);
    endfunction

    cfg_t regs;

    ptgs_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [31:0]    px_reg, py_reg, pz_reg;
    logic [7:0]     red_reg;
    logic [7:0]     rr_reg, rc_reg;
    logic           rd_clear_reg;
    logic [1:0]     mul_sel_reg, mul_sel_next;
    logic [31:0]    col_q_reg, row_q_reg, gray_q_reg;
    logic [RW-1:0]  r_reg, r_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [3:0]     grp_en_reg, grp_en_next;
    logic [7:0]     g_reg, g_next;
    logic [3:0]     nb_reg, nb_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_addr_reg, pend_addr_next;
    logic           out_valid_reg, out_valid_next;
    pixel_t         out_reg, out_next;

    logic           accept;
    logic [31:0]    mul_a, mul_lo, mul_scale, mul_pos;
    logic signed [32:0] mul_diff;
    logic [63:0]    mul_prod;

    logic [2:0]     nb_k;
    logic [RW:0]    nb_row;
    logic [CW:0]    nb_col;
    logic [AW-1:0]  nb_addr;
    logic           rd_oob;
    logic [RW-1:0]  rd_row;
    logic [AW-1:0]  rd_addr;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    pixel_t         ram_wdata, ram_rdata;
    pixel_t         splat_pix;

    ptgs_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (CELLS)
    ) u_planes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign points.ready = (state_reg == S_IDLE);
    assign accept = points.valid && points.ready;

    assign pixels.valid         = out_valid_reg;
    assign pixels.depth_out     = out_reg.depth;
    assign pixels.gray_out      = out_reg.gray;
    assign pixels.intensity_out = out_reg.inten;

    // Shared multiplier: integer part of max(a - lo, 0) * scale.
    always_comb
    begin
        case (mul_sel_reg)
            2'd0:
            begin
                mul_a = px_reg;
                mul_lo = regs.x_min;
                mul_scale = regs.x_inv_pitch;
            end
            2'd1:
            begin
                mul_a = py_reg;
                mul_lo = regs.y_min;
                mul_scale = regs.y_inv_pitch;
            end
            default:
            begin
                mul_a = pz_reg;
                mul_lo = regs.z_min;
                mul_scale = regs.gray_factor;
            end
        endcase
        mul_diff = $signed({mul_a[31], mul_a}) - $signed({mul_lo[31], mul_lo});
        mul_pos  = (mul_diff > 33'sd0) ? mul_diff[31:0] : 32'd0;
        mul_prod = 64'(mul_pos) * 64'(mul_scale);
    end

    // Neighbor address for the current step, and the read address with its range check.
    always_comb
    begin
        nb_k    = 3'(nb_reg - 4'd1);
        nb_row  = (RW+1)'({1'b0, r_reg}) + (RW+1)'(signed'(NB_DR[nb_k]));
        nb_col  = (CW+1)'({1'b0, c_reg}) + (CW+1)'(signed'(NB_DC[nb_k]));
        nb_addr = addr_of(nb_row[RW-1:0], nb_col[CW-1:0]);
        rd_oob  = (32'(rr_reg) >= 32'(ROWS)) || (32'(rc_reg) >= 32'(COLS));
        rd_row  = RW'(ROWS - 1) - RW'(rr_reg);
        rd_addr = addr_of(rd_row, CW'(rc_reg));
    end

    assign splat_pix = '{depth: pz_reg, gray: g_reg, inten: red_reg};

    // Plane RAM port steering.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = fill_pixel(ram_rdata, splat_pix, regs.z_min);
        ram_raddr = (state_reg == S_SPLAT) ? nb_addr : rd_addr;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_SPLAT && nb_reg == 4'd0)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_of(r_reg, c_reg);
            ram_wdata = splat_pix;
        end
        else if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_RD_DATA && rd_clear_reg && !rd_oob)
        begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr;
            ram_wdata = '{depth: regs.z_min, gray: 8'd0, inten: 8'd0};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        mul_sel_next   = mul_sel_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        grp_en_next    = grp_en_reg;
        g_next         = g_reg;
        nb_next        = nb_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && !pixels.ready;
        out_next       = out_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (points.operation)
                        OP_SPLAT:
                        begin
                            state_next   = S_MUL;
                            mul_sel_next = 2'd0;
                        end
                        OP_READ, OP_READ_CLR:
                        begin
                            state_next = S_RD_ISSUE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                mul_sel_next = mul_sel_reg + 2'd1;
                if (mul_sel_reg == 2'd2)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                r_next = row_q_reg[RW-1:0];
                c_next = col_q_reg[CW-1:0];
                g_next = (gray_q_reg > 32'(GRAY_MAX)) ? GRAY_MAX : gray_q_reg[7:0];
                grp_en_next[GRP_UP_LEFT] = (row_q_reg >= 32'd2) && (col_q_reg >= 32'd2);
                grp_en_next[GRP_DOWN_RIGHT] = (row_q_reg < 32'(ROWS - 1))
                                              && (col_q_reg < 32'(COLS - 1));
                grp_en_next[GRP_LEFT_DOWN] = (col_q_reg >= 32'd2)
                                             && (row_q_reg < 32'(ROWS - 1));
                grp_en_next[GRP_RIGHT_UP] = (col_q_reg < 32'(COLS - 1))
                                            && (row_q_reg >= 32'd2);
                nb_next = 4'd0;
                if (col_q_reg >= 32'd1 && col_q_reg < 32'(COLS)
                    && row_q_reg >= 32'd1 && row_q_reg < 32'(ROWS))
                begin
                    state_next = S_SPLAT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPLAT:
            begin
                // Read of one neighbor overlaps the write-back of the one before.
                nb_next = nb_reg + 4'd1;
                if (nb_reg != 4'd0)
                begin
                    pend_next      = grp_en_reg[NB_GRP[nb_k]];
                    pend_addr_next = nb_addr;
                end
                if (nb_reg == 4'd8)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            S_RD_ISSUE:
            begin
                if (!out_valid_reg || pixels.ready)
                begin
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                out_valid_next = 1'b1;
                out_next       = rd_oob ? '0 : ram_rdata;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            mul_sel_reg   <= 2'd0;
            nb_reg        <= 4'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mul_sel_reg   <= mul_sel_next;
            nb_reg        <= nb_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= points.point_x;
            py_reg       <= points.point_y;
            pz_reg       <= points.point_z;
            red_reg      <= points.point_red;
            rr_reg       <= points.read_row;
            rc_reg       <= points.read_col;
            rd_clear_reg <= (points.operation == OP_READ_CLR);
        end
        if (state_reg == S_MUL)
        begin
            case (mul_sel_reg)
                2'd0:    col_q_reg <= mul_prod[63:32];
                2'd1:    row_q_reg <= mul_prod[63:32];
                default: gray_q_reg <= mul_prod[63:32];
            endcase
        end
        r_reg         <= r_next;
        c_reg         <= c_next;
        grp_en_reg    <= grp_en_next;
        g_reg         <= g_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    `PTGS_ASSERT(a_rd_slot_free, (state_reg == S_RD_DATA) |-> !out_valid_reg, "read data arrived with result slot full")
    `PTGS_NEVER(a_no_take_in_clear, (state_reg == S_CLEAR) && points.ready, "points taken during clearing pass")
    `PTGS_ASSERT(a_check_exit, (state_reg == S_CHECK) |=> (state_reg == S_IDLE || state_reg == S_SPLAT), "range check went to a wrong state")
    `PTGS_NEVER(a_centre_no_pend, (state_reg == S_SPLAT) && (nb_reg == 4'd0) && pend_reg, "centre write collides with a pending fill")

endmodule
